@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: expr");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: ante then cons");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/deq_pkg.sv @@
// ---------------------------------------------------------------------------
// deq_pkg
// types and codes shared by the deque cells, chains and top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_pkg;

  localparam int ItemW   = 32;
  localparam int ReqW    = 3;
  localparam int CountW  = 7;
  localparam int StatusW = 2;

  localparam logic [ReqW-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [ReqW-1:0] REQ_PUSH_REAR  = 3'd1;
  localparam logic [ReqW-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [ReqW-1:0] REQ_POP_REAR   = 3'd3;

  localparam logic [StatusW-1:0] ST_DONE      = 2'd0;
  localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd2;

  // per-cell control, one-hot or all zero (hold)
  typedef struct packed {
    logic shift_up;    // take the value of the lower neighbor
    logic shift_down;  // take the value of the upper neighbor
    logic load;        // take the pushed item
  } deq_cell_ctl_t;

  // operation on one chain, seen from its head cell
  typedef struct packed {
    logic push_head;
    logic push_tail;
    logic pop_head;
  } deq_chain_op_t;

endpackage

@@ hdl/double_ended_queue.sv @@
// ---------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed 32-bit items built from two chains of cells
// ---------------------------------------------------------------------------
// usage:
//   a request (req_type, data_in) enters on in_valid/in_ready; it pushes at
//   the front or rear, pops the front or rear, or only peeks (codes 4 to 7)
//   one result per request leaves on out_valid/out_ready: front and rear
//   items after the request (0 when empty), empty flag, entry count taken
//   modulo 128, and status (done, underflow, overflow)
//   latency: the result is valid the cycle after the request is accepted
//   throughput: one request per cycle while the receiver keeps up; every cell moves in the same cycle,
//   so the only loop is the registered update of the cell rows and the count
//   a waiting result does not block the next request when out_ready is high
//   in the same cycle; while the receiver stalls, in_ready stays low and the
//   result holds
//   reset clears the count and the result valid flag; cell contents are
//   unknown until pushed and are never shown
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ReqW-1:0]           req_type,
  input  logic signed [ItemW-1:0]   data_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ItemW-1:0]   front_item,
  output logic signed [ItemW-1:0]   rear_item,
  output logic                      empty_flag,
  output logic [CountW-1:0]         entry_count,
  output logic [StatusW-1:0]        status
);

`include "assert_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);

  // items held, 0..DEPTH
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [StatusW-1:0] status_next;
  logic               out_valid_next;

  logic in_acc;
  logic full;
  logic empty;
  logic is_push;
  logic is_pop;
  logic do_push_front;
  logic do_push_rear;
  logic do_pop_front;
  logic do_pop_rear;

  deq_chain_op_t           fwd_op;
  deq_chain_op_t           rev_op;
  logic signed [ItemW-1:0] fwd_head;
  logic signed [ItemW-1:0] rev_head;

  // next request may enter as the current result leaves
  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  assign is_push = (req_type == REQ_PUSH_FRONT) || (req_type == REQ_PUSH_REAR);
  assign is_pop  = (req_type == REQ_POP_FRONT) || (req_type == REQ_POP_REAR);

  // requests that really change the deque
  assign do_push_front = in_acc && (req_type == REQ_PUSH_FRONT) && !full;
  assign do_push_rear  = in_acc && (req_type == REQ_PUSH_REAR) && !full;
  assign do_pop_front  = in_acc && (req_type == REQ_POP_FRONT) && !empty;
  assign do_pop_rear   = in_acc && (req_type == REQ_POP_REAR) && !empty;

  // forward chain: cell 0 holds the front item
  assign fwd_op.push_head = do_push_front;
  assign fwd_op.push_tail = do_push_rear;
  assign fwd_op.pop_head  = do_pop_front;

  // reverse chain: same items in reverse order, cell 0 holds the rear item
  assign rev_op.push_head = do_push_rear;
  assign rev_op.push_tail = do_push_front;
  assign rev_op.pop_head  = do_pop_rear;

  deq_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_fwd_chain (
    .clk      (clk),
    .op       (fwd_op),
    .count    (count),
    .data     (data_in),
    .head_val (fwd_head)
  );

  deq_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_rev_chain (
    .clk      (clk),
    .op       (rev_op),
    .count    (count),
    .data     (data_in),
    .head_val (rev_head)
  );

  always_comb begin
    count_next = count;
    if (do_push_front || do_push_rear) begin
      count_next = count + CW'(1);
    end else if (do_pop_front || do_pop_rear) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    status_next = status;
    if (in_acc) begin
      if (is_push && full) begin
        status_next = ST_OVERFLOW;
      end else if (is_pop && empty) begin
        status_next = ST_UNDERFLOW;
      end else begin
        status_next = ST_DONE;
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (in_acc) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // status is payload, it only means something while out_valid is high
  always_ff @(posedge clk) begin
    status <= status_next;
  end

  // result fields come straight from the head cells and the count
  assign front_item  = empty ? '0 : fwd_head;
  assign rear_item   = empty ? '0 : rev_head;
  assign empty_flag  = empty;
  assign entry_count = CountW'(count);

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `ASSERT_NEXT(a_overflow_holds, clk, rst, in_acc && is_push && full, status == ST_OVERFLOW && $stable(count))
  `ASSERT_NEXT(a_underflow_holds, clk, rst, in_acc && is_pop && empty, status == ST_UNDERFLOW && $stable(count))
  `ASSERT_NEXT(a_result_follows, clk, rst, in_acc, out_valid)
  `ASSERT_IMPLIES(a_stall_blocks, clk, rst, out_valid && !out_ready, !in_ready)

endmodule

@@ hdl/deq_cell.sv @@
// ---------------------------------------------------------------------------
// deq_cell
// one storage cell of a deque chain, shifts either way or loads an item
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_cell
  import deq_pkg::*;
(
  input  logic                    clk,
  input  deq_cell_ctl_t           ctl,
  input  logic signed [ItemW-1:0] lower_val,
  input  logic signed [ItemW-1:0] upper_val,
  input  logic signed [ItemW-1:0] wr_data,
  output logic signed [ItemW-1:0] val
);

  logic signed [ItemW-1:0] val_next;

  always_comb begin
    if (ctl.shift_up) begin
      val_next = lower_val;
    end else if (ctl.shift_down) begin
      val_next = upper_val;
    end else if (ctl.load) begin
      val_next = wr_data;
    end else begin
      val_next = val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

@@ hdl/deq_chain.sv @@
// ---------------------------------------------------------------------------
// deq_chain
// row of cells holding the deque packed against cell 0 (the head)
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_chain
  import deq_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int CW    = 7
) (
  input  logic                    clk,
  input  deq_chain_op_t           op,
  input  logic [CW-1:0]           count,
  input  logic signed [ItemW-1:0] data,
  output logic signed [ItemW-1:0] head_val
);

  logic signed [ItemW-1:0] cell_val [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_cell_ctl_t           ctl;
    logic signed [ItemW-1:0] lower_val;
    logic signed [ItemW-1:0] upper_val;

    assign ctl.shift_up   = op.push_head;
    assign ctl.shift_down = op.pop_head;
    // tail push lands in the first free cell
    assign ctl.load       = op.push_tail && (count == CW'(i));

    if (i == 0) begin : g_first
      assign lower_val = data;
    end else begin : g_inner_lo
      assign lower_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_val = cell_val[i];
    end else begin : g_inner_hi
      assign upper_val = cell_val[i+1];
    end

    deq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .lower_val (lower_val),
      .upper_val (upper_val),
      .wr_data   (data),
      .val       (cell_val[i])
    );
  end

  assign head_val = cell_val[0];

endmodule

@@ bench/double_ended_queue_test.sv @@
// ---------------------------------------------------------------------------
// double_ended_queue_test
// self-checking bench for the bounded double-ended queue
// ---------------------------------------------------------------------------
// a request queue filled up front feeds a clocked driver; every accepted
// request runs through a queue-based deque model that predicts the result,
// and a clocked monitor compares each returned result field by field;
// both sides idle in random bursts, the sender pauses for a full drain at
// least once, and the closing stretch runs with no idling at all
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_test;
  import deq_pkg::*;

  localparam int DEPTH       = 64;
  localparam int RANDOM_END  = 710;   // directed plus random requests before the calm tail
  localparam int QUIET_ITEMS = 60;    // closing requests with no idling on either side
  localparam int IDLE_LIMIT  = 1000;  // cycles with no handshake before giving up
  localparam int DRAIN_WAIT  = 20;    // settle time after the last result
  localparam int SHOW_LIMIT  = 10;

  // request codes that the package leaves unnamed
  localparam logic [ReqW-1:0] REQ_PEEK  = 3'd4;
  localparam logic [ReqW-1:0] REQ_RSVD5 = 3'd5;
  localparam logic [ReqW-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [ReqW-1:0] REQ_RSVD7 = 3'd7;

  localparam logic signed [ItemW-1:0] ITEM_MIN = {1'b1, {(ItemW-1){1'b0}}};
  localparam logic signed [ItemW-1:0] ITEM_MAX = {1'b0, {(ItemW-1){1'b1}}};

  typedef struct {
    logic [ReqW-1:0]         req;
    logic signed [ItemW-1:0] data;
    int unsigned             gap_after;  // sender idle cycles after this request
    bit                      hold;       // wait for every result before sending
    bit                      quiet;      // part of the closing stretch
  } deq_request_t;

  typedef struct {
    logic signed [ItemW-1:0] front;
    logic signed [ItemW-1:0] rear;
    logic                    empty;
    logic [CountW-1:0]       count;
    logic [StatusW-1:0]      st;
  } deq_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [ReqW-1:0]         req_type = REQ_PEEK;
  logic signed [ItemW-1:0] data_in = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [ItemW-1:0] front_item;
  logic signed [ItemW-1:0] rear_item;
  logic                    empty_flag;
  logic [CountW-1:0]       entry_count;
  logic [StatusW-1:0]      status;

  // request queue feeding the driver, and results still owed by the block
  deq_request_t pending_requests[$];
  deq_result_t  owed_results[$];

  // deque model contents, front at index 0
  logic signed [ItemW-1:0] deque_items[$];

  int unsigned queued_cnt = 0;
  int unsigned planned_fill = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned underflow_cnt = 0;
  int unsigned overflow_cnt = 0;
  int unsigned peak_fill = 0;
  bit          rx_quiet = 1'b0;

  deq_request_t next_req;
  deq_result_t  predicted;
  deq_result_t  wanted;

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .data_in    (data_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .front_item (front_item),
    .rear_item  (rear_item),
    .empty_flag (empty_flag),
    .entry_count(entry_count),
    .status     (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the deque model and return what the block must report
  function automatic deq_result_t apply_request(logic [ReqW-1:0] req,
                                                logic signed [ItemW-1:0] data);
    deq_result_t r;
    r.st = ST_DONE;
    case (req)
      REQ_PUSH_FRONT: begin
        if (deque_items.size() >= DEPTH) r.st = ST_OVERFLOW;
        else deque_items.push_front(data);
      end
      REQ_PUSH_REAR: begin
        if (deque_items.size() >= DEPTH) r.st = ST_OVERFLOW;
        else deque_items.push_back(data);
      end
      REQ_POP_FRONT: begin
        if (deque_items.size() == 0) r.st = ST_UNDERFLOW;
        else void'(deque_items.pop_front());
      end
      REQ_POP_REAR: begin
        if (deque_items.size() == 0) r.st = ST_UNDERFLOW;
        else void'(deque_items.pop_back());
      end
      default: ;  // peek and the unused codes leave the contents alone
    endcase
    r.empty = (deque_items.size() == 0);
    r.front = r.empty ? '0 : deque_items[0];
    r.rear  = r.empty ? '0 : deque_items[$];
    r.count = CountW'(deque_items.size());
    return r;
  endfunction

  // item values lean toward the extremes now and then
  function automatic logic signed [ItemW-1:0] pick_item();
    case ($urandom_range(0, 15))
      0:       return ITEM_MIN;
      1:       return ITEM_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ReqW-1:0] pick_peek_code();
    case ($urandom_range(0, 7))
      0:       return REQ_RSVD5;
      1:       return REQ_RSVD6;
      2:       return REQ_RSVD7;
      default: return REQ_PEEK;
    endcase
  endfunction

  function automatic logic [ReqW-1:0] pick_push_op();
    return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
  endfunction

  function automatic logic [ReqW-1:0] pick_pop_op();
    return $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_REAR;
  endfunction

  function automatic logic [ReqW-1:0] pick_walk_op();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return pick_push_op();
    if (roll < 8) return pick_pop_op();
    return pick_peek_code();
  endfunction

  // sender gap after a request: none in busy stretches, else a burst now and then
  function automatic int unsigned pick_gap(bit busy);
    if (busy || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 9);
  endfunction

  // append one request and track the fill level the generator is steering
  task automatic queue_request(logic [ReqW-1:0] req, logic signed [ItemW-1:0] data,
                               int unsigned gap, bit hold, bit quiet);
    deq_request_t r;
    r.req = req;
    r.data = data;
    r.gap_after = gap;
    r.hold = hold;
    r.quiet = quiet;
    pending_requests.push_back(r);
    queued_cnt++;
    if ((req == REQ_PUSH_FRONT || req == REQ_PUSH_REAR) && planned_fill < DEPTH)
      planned_fill++;
    else if ((req == REQ_POP_FRONT || req == REQ_POP_REAR) && planned_fill > 0)
      planned_fill--;
  endtask

  // driver: predict on every accepted request, then load the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = apply_request(req_type, data_in);
        owed_results.push_back(predicted);
        accepted_cnt <= accepted_cnt + 1;
        if (predicted.st == ST_UNDERFLOW) underflow_cnt++;
        if (predicted.st == ST_OVERFLOW) overflow_cnt++;
        if (deque_items.size() > peak_fill) peak_fill = deque_items.size();
      end
      // a new request may be loaded once the current one is gone
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_requests[0].hold &&
                     (accepted_cnt != checked_cnt || (in_valid && in_ready))) begin
          // hold off until the block has returned every owed result
          in_valid <= 1'b0;
        end else begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          req_type <= next_req.req;
          data_in  <= next_req.data;
          gap_left <= next_req.gap_after;
          if (next_req.quiet) rx_quiet <= 1'b1;
        end
      end
    end
  end

  // monitor: check each returned result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        checked_cnt <= checked_cnt + 1;
        if (checked_cnt >= accepted_cnt) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("result %0d came with no request outstanding", checked_cnt);
        end else begin
          wanted = owed_results.pop_front();
          if (front_item !== wanted.front || rear_item !== wanted.rear ||
              empty_flag !== wanted.empty || entry_count !== wanted.count ||
              status !== wanted.st) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT) begin
              $display("result %0d expected front=%0d rear=%0d empty=%0b count=%0d status=%0d",
                       checked_cnt, wanted.front, wanted.rear, wanted.empty,
                       wanted.count, wanted.st);
              $display("result %0d actual   front=%0d rear=%0d empty=%0b count=%0d status=%0d",
                       checked_cnt, front_item, rear_item, empty_flag, entry_count, status);
            end
          end
        end
      end
      // receiver stalls: random bursts, calm stretches, none at the close
      if (rx_quiet) begin
        out_ready <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left <= calm_left - 1;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            calm_left <= $urandom_range(20, 80);
            out_ready <= 1'b1;
          end
          1, 2, 3, 4: begin
            stall_left <= $urandom_range(0, 8);
            out_ready <= 1'b0;
          end
          default: out_ready <= 1'b1;
        endcase
      end
    end
  end

  // watchdog: too long without any useful handshake means the block is stuck;
  // results nobody asked for do not count as progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) ||
        (out_valid && out_ready && checked_cnt < accepted_cnt)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no handshake for %0d cycles, %0d of %0d requests taken, %0d results checked",
               IDLE_LIMIT, accepted_cnt, queued_cnt, checked_cnt);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned kind;
    int unsigned reps;
    bit          busy;
    bit          hold;

    // directed: underflow on empty, peeks and unused codes, extreme items,
    // a single held item, a drain to empty and a pause for every result
    queue_request(REQ_POP_FRONT, pick_item(), pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_POP_REAR, pick_item(), pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_PEEK, ITEM_MAX, pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_RSVD5, ITEM_MIN, pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_PUSH_FRONT, ITEM_MIN, pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_PUSH_REAR, ITEM_MAX, pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_PEEK, pick_item(), pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_PUSH_FRONT, '0, pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_PUSH_REAR, '1, pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_RSVD6, pick_item(), pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_POP_REAR, pick_item(), pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_POP_FRONT, pick_item(), pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_PUSH_REAR, 32'sh5555_5555, pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_PUSH_FRONT, 32'shAAAA_AAAA, pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_RSVD7, pick_item(), pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_POP_FRONT, pick_item(), pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_POP_FRONT, pick_item(), pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_POP_REAR, pick_item(), pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_POP_REAR, pick_item(), pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_POP_FRONT, pick_item(), pick_gap(0), 1'b0, 1'b0);
    queue_request(REQ_PUSH_REAR, pick_item(), pick_gap(0), 1'b1, 1'b0);
    queue_request(REQ_POP_FRONT, pick_item(), pick_gap(0), 1'b0, 1'b0);

    // random: fills to full with overflow, drains to empty with underflow,
    // and random walks in between
    while (queued_cnt < RANDOM_END) begin
      kind = $urandom_range(0, 9);
      busy = ($urandom_range(0, 3) == 0);
      hold = ($urandom_range(0, 7) == 0);
      if (kind < 2) begin
        while (planned_fill < DEPTH) begin
          queue_request(($urandom_range(0, 9) == 0) ? pick_peek_code() : pick_push_op(),
                        pick_item(), pick_gap(busy), hold, 1'b0);
          hold = 1'b0;
        end
        reps = $urandom_range(1, 3);
        repeat (reps) queue_request(pick_push_op(), pick_item(), pick_gap(busy), hold, 1'b0);
      end else if (kind < 4) begin
        while (planned_fill > 0) begin
          queue_request(($urandom_range(0, 9) == 0) ? pick_peek_code() : pick_pop_op(),
                        pick_item(), pick_gap(busy), hold, 1'b0);
          hold = 1'b0;
        end
        reps = $urandom_range(1, 2);
        repeat (reps) queue_request(pick_pop_op(), pick_item(), pick_gap(busy), hold, 1'b0);
      end else begin
        reps = $urandom_range(20, 60);
        repeat (reps) begin
          queue_request(pick_walk_op(), pick_item(), pick_gap(busy), hold, 1'b0);
          hold = 1'b0;
        end
      end
    end

    // closing stretch at full rate on both sides
    repeat (QUIET_ITEMS) queue_request(pick_walk_op(), pick_item(), 0, 1'b0, 1'b1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // wait for every request to be taken and every result to come back
    do @(posedge clk);
    while (accepted_cnt != queued_cnt || checked_cnt < accepted_cnt);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d requests: %0d underflows, %0d overflows, peak fill %0d of %0d",
             accepted_cnt, underflow_cnt, overflow_cnt, peak_fill, DEPTH);
    $display("checked %0d results, %0d mismatches", checked_cnt, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/deq_chain.sv
hdl/double_ended_queue.sv
bench/double_ended_queue_test.sv
